@@ hw/rtl/lpbc_pkg.sv @@
`default_nettype none
package lpbc_pkg;

  localparam int PanelWidthDef  = 320;
  localparam int PanelHeightDef = 240;

  localparam int ActionW = 2;
  localparam int ByteW   = 8;
  localparam int ReadXW  = 9;
  localparam int ReadYW  = 8;
  localparam int PixelW  = 16;
  localparam int CountW  = 32;
  localparam int CoordW  = 16;

  typedef enum logic [ActionW-1:0] {
    ACT_DATA = 2'd0,
    ACT_CMD  = 2'd1,
    ACT_PIN  = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  localparam logic [ByteW-1:0] CMD_SWRESET = 8'h01;
  localparam logic [ByteW-1:0] CMD_DISPOFF = 8'h28;
  localparam logic [ByteW-1:0] CMD_DISPON  = 8'h29;
  localparam logic [ByteW-1:0] CMD_CASET   = 8'h2a;
  localparam logic [ByteW-1:0] CMD_RASET   = 8'h2b;
  localparam logic [ByteW-1:0] CMD_RAMWR   = 8'h2c;
  localparam logic [ByteW-1:0] CMD_MADCTL  = 8'h36;

  localparam logic [2:0] PARAM_SAT = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_READ  = 2'd2
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/lpbc_if.sv @@
`default_nettype none
interface lpbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpbc_pkg::ActionW-1:0] action;
  logic [lpbc_pkg::ByteW-1:0]   value;
  logic [lpbc_pkg::ReadXW-1:0]  read_x;
  logic [lpbc_pkg::ReadYW-1:0]  read_y;

  modport source (output valid, action, value, read_x, read_y, input ready);
  modport sink   (input valid, action, value, read_x, read_y, output ready);
endinterface

interface lpbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpbc_pkg::PixelW-1:0] read_pixel;
  logic                        display_enabled;
  logic [lpbc_pkg::CountW-1:0] pixel_write_count;
  logic [lpbc_pkg::CountW-1:0] sweep_count;
  logic [lpbc_pkg::ByteW-1:0]  orientation;

  modport source (output valid, read_pixel, display_enabled, pixel_write_count,
                  sweep_count, orientation, input ready);
  modport sink   (input valid, read_pixel, display_enabled, pixel_write_count,
                  sweep_count, orientation, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lpbc_frame_mem.sv @@
`default_nettype none
// Single write port, single registered read port.
module lpbc_frame_mem #(
  parameter int DEPTH  = lpbc_pkg::PanelWidthDef * lpbc_pkg::PanelHeightDef,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [lpbc_pkg::PixelW-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [lpbc_pkg::PixelW-1:0] rdata
);

  logic [lpbc_pkg::PixelW-1:0] mem [DEPTH];
  logic [lpbc_pkg::PixelW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/lcd_panel_bus_controller.sv @@
`default_nettype none
// Parallel-bus display controller with an on-chip framebuffer.
//
// in_bus  : one transaction per bus action (data byte, command byte, reset
//           pin level, pixel read). valid/ready handshake.
// out_bus : exactly one result transaction per input transaction, in order:
//           read pixel (zero unless a read), display flag, pixel write count,
//           sweep count and orientation byte as they stand after the action.
//
// Writes and pin actions produce their result in the cycle after the input
// transaction; a pixel read first registers the framebuffer read port output
// and then loads the output register in state ST_READ, with in_bus.ready low.
// Throughput is one transaction per cycle for writes while out_bus does not stall.
// The output register decouples the sides: a new transaction is taken in the
// cycle the pending result is consumed; while out_bus stalls with a result
// held, in_bus.ready stays low.
// Reset (rst_n low) and the software reset command both start a clearing pass
// that zeroes the framebuffer one entry per cycle, all PANEL_WIDTH*PANEL_HEIGHT
// entries (76800 at default size), with in_bus.ready low; the software reset
// result itself is delivered normally. A falling edge on the reset pin
// restarts the command engine but keeps pixels, display flag and counters.
module lcd_panel_bus_controller #(
  parameter int PANEL_WIDTH  = lpbc_pkg::PanelWidthDef,
  parameter int PANEL_HEIGHT = lpbc_pkg::PanelHeightDef
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpbc_in_if.sink    in_bus,
  lpbc_out_if.source out_bus
);

  localparam int DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = lpbc_pkg::CoordW;

  localparam logic [CW-1:0] COL_LAST_RST = CW'(PANEL_WIDTH - 1);
  localparam logic [CW-1:0] ROW_LAST_RST = CW'(PANEL_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  lpbc_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [7:0]     cmd_r, cmd_nxt;
  logic [2:0]     pidx_r, pidx_nxt;
  logic [CW-1:0]  col_first_r, col_first_nxt, col_last_r, col_last_nxt;
  logic [CW-1:0]  row_first_r, row_first_nxt, row_last_r, row_last_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt, cur_row_r, cur_row_nxt;
  logic           ramwr_r, ramwr_nxt;
  logic [7:0]     hi_byte_r, hi_byte_nxt;
  logic           hi_held_r, hi_held_nxt;
  logic [7:0]     orient_r, orient_nxt;
  logic           pin_r, pin_nxt;
  logic signed [CW:0] last_sweep_r, last_sweep_nxt;
  logic           disp_r, disp_nxt;
  logic [31:0]    wr_cnt_r, wr_cnt_nxt;
  logic [31:0]    sweep_cnt_r, sweep_cnt_nxt;

  logic rd_ok_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_pixel_r;
  logic        out_disp_r;
  logic [31:0] out_wr_cnt_r;
  logic [31:0] out_sweep_r;
  logic [7:0]  out_orient_r;

  // ---------------------------------------------------------------------
  // Handshake and decode
  // ---------------------------------------------------------------------
  logic              in_ready;
  logic              acc;
  lpbc_pkg::action_t act;
  logic [7:0]        val;
  logic              pix_we;
  logic              start_clear;
  logic              do_restart;
  logic              rd_issue;
  logic              load_out;

  assign acc = in_bus.valid && in_ready;
  assign act = lpbc_pkg::action_t'(in_bus.action);
  assign val = in_bus.value;

  // Linear addresses: one multiply each, row * width + column.
  logic [31:0] wr_lin, rd_lin;
  logic        cur_on_panel, rd_on_panel;

  assign wr_lin = 32'(cur_row_r) * 32'(PANEL_WIDTH) + 32'(cur_col_r);
  assign rd_lin = 32'(in_bus.read_y) * 32'(PANEL_WIDTH) + 32'(in_bus.read_x);
  assign cur_on_panel = (32'(cur_col_r) < 32'(PANEL_WIDTH)) &&
                        (32'(cur_row_r) < 32'(PANEL_HEIGHT));
  assign rd_on_panel  = (32'(in_bus.read_x) < 32'(PANEL_WIDTH)) &&
                        (32'(in_bus.read_y) < 32'(PANEL_HEIGHT));

  // ---------------------------------------------------------------------
  // Command engine next state
  // ---------------------------------------------------------------------
  logic [CW:0] col_inc, row_inc;
  assign col_inc = {1'b0, cur_col_r} + (CW+1)'(1);
  assign row_inc = {1'b0, cur_row_r} + (CW+1)'(1);

  always_comb begin
    cmd_nxt        = cmd_r;
    pidx_nxt       = pidx_r;
    col_first_nxt  = col_first_r;
    col_last_nxt   = col_last_r;
    row_first_nxt  = row_first_r;
    row_last_nxt   = row_last_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    ramwr_nxt      = ramwr_r;
    hi_byte_nxt    = hi_byte_r;
    hi_held_nxt    = hi_held_r;
    orient_nxt     = orient_r;
    pin_nxt        = pin_r;
    last_sweep_nxt = last_sweep_r;
    disp_nxt       = disp_r;
    wr_cnt_nxt     = wr_cnt_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    pix_we         = 1'b0;
    start_clear    = 1'b0;
    do_restart     = 1'b0;

    if (acc) begin
      case (act)
        lpbc_pkg::ACT_DATA: begin
          if (ramwr_r) begin
            if (!hi_held_r) begin
              hi_byte_nxt = val;
              hi_held_nxt = 1'b1;
            end else begin
              hi_held_nxt = 1'b0;
              pix_we      = cur_on_panel;
              wr_cnt_nxt  = wr_cnt_r + 32'd1;
              if (col_inc > {1'b0, col_last_r}) begin
                cur_col_nxt = col_first_r;
                if (row_inc > {1'b0, row_last_r}) begin
                  cur_row_nxt = row_first_r;
                end else begin
                  cur_row_nxt = row_inc[CW-1:0];
                end
              end else begin
                cur_col_nxt = col_inc[CW-1:0];
              end
            end
          end else begin
            if (cmd_r == lpbc_pkg::CMD_CASET) begin
              case (pidx_r)
                3'd0:    col_first_nxt = {val, 8'h00};
                3'd1:    col_first_nxt = col_first_r | {8'h00, val};
                3'd2:    col_last_nxt  = {val, 8'h00};
                3'd3:    col_last_nxt  = col_last_r | {8'h00, val};
                default: ;
              endcase
            end else if (cmd_r == lpbc_pkg::CMD_RASET) begin
              case (pidx_r)
                3'd0:    row_first_nxt = {val, 8'h00};
                3'd1:    row_first_nxt = row_first_r | {8'h00, val};
                3'd2:    row_last_nxt  = {val, 8'h00};
                3'd3:    row_last_nxt  = row_last_r | {8'h00, val};
                default: ;
              endcase
            end else if (cmd_r == lpbc_pkg::CMD_MADCTL) begin
              orient_nxt = val;
            end
            if (pidx_r < lpbc_pkg::PARAM_SAT) begin
              pidx_nxt = pidx_r + 3'd1;
            end
          end
        end
        lpbc_pkg::ACT_CMD: begin
          cmd_nxt     = val;
          pidx_nxt    = 3'd0;
          ramwr_nxt   = (val == lpbc_pkg::CMD_RAMWR);
          hi_held_nxt = 1'b0;
          if (val == lpbc_pkg::CMD_RAMWR) begin
            cur_col_nxt = col_first_r;
            cur_row_nxt = row_first_r;
            // single-column window at or left of the previous one ends a sweep
            if (col_last_r == col_first_r) begin
              if ($signed({1'b0, col_first_r}) <= last_sweep_r) begin
                sweep_cnt_nxt = sweep_cnt_r + 32'd1;
              end
              last_sweep_nxt = $signed({1'b0, col_first_r});
            end
          end
          if (val == lpbc_pkg::CMD_DISPON) begin
            disp_nxt = 1'b1;
          end else if (val == lpbc_pkg::CMD_DISPOFF) begin
            disp_nxt = 1'b0;
          end else if (val == lpbc_pkg::CMD_SWRESET) begin
            do_restart  = 1'b1;
            start_clear = 1'b1;
            disp_nxt    = 1'b0;
            wr_cnt_nxt  = 32'd0;
          end
        end
        lpbc_pkg::ACT_PIN: begin
          if (pin_r && !val[0]) begin
            do_restart = 1'b1;
          end
          pin_nxt = val[0];
        end
        default: ;  // pixel read leaves the state alone
      endcase
    end

    if (do_restart) begin
      cmd_nxt        = 8'h00;
      pidx_nxt       = 3'd0;
      col_first_nxt  = '0;
      col_last_nxt   = COL_LAST_RST;
      row_first_nxt  = '0;
      row_last_nxt   = ROW_LAST_RST;
      cur_col_nxt    = '0;
      cur_row_nxt    = '0;
      ramwr_nxt      = 1'b0;
      hi_byte_nxt    = 8'h00;
      hi_held_nxt    = 1'b0;
      orient_nxt     = 8'h00;
      last_sweep_nxt = '1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpbc_pkg::ST_CLEAR: begin
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = lpbc_pkg::ST_IDLE;
        end
      end
      lpbc_pkg::ST_IDLE: begin
        if (acc && act == lpbc_pkg::ACT_READ) begin
          state_nxt = lpbc_pkg::ST_READ;
        end else if (start_clear) begin
          state_nxt = lpbc_pkg::ST_CLEAR;
        end
      end
      lpbc_pkg::ST_READ: state_nxt = lpbc_pkg::ST_IDLE;
      default:           state_nxt = lpbc_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    load_out = 1'b0;
    case (state_r)
      lpbc_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_bus.ready;
        rd_issue = acc && act == lpbc_pkg::ACT_READ;
        load_out = acc && act != lpbc_pkg::ACT_READ;
      end
      lpbc_pkg::ST_READ: load_out = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Framebuffer
  // ---------------------------------------------------------------------
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [15:0]       mem_rdata;

  always_comb begin
    if (state_r == lpbc_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 16'h0000;
    end else begin
      mem_we    = pix_we;
      mem_waddr = wr_lin[ADDR_W-1:0];
      mem_wdata = {hi_byte_r, val};
    end
  end

  lpbc_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_issue),
    .raddr (rd_lin[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lpbc_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      cmd_r        <= 8'h00;
      pidx_r       <= 3'd0;
      col_first_r  <= '0;
      col_last_r   <= COL_LAST_RST;
      row_first_r  <= '0;
      row_last_r   <= ROW_LAST_RST;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      ramwr_r      <= 1'b0;
      hi_byte_r    <= 8'h00;
      hi_held_r    <= 1'b0;
      orient_r     <= 8'h00;
      pin_r        <= 1'b1;
      last_sweep_r <= '1;
      disp_r       <= 1'b0;
      wr_cnt_r     <= 32'd0;
      sweep_cnt_r  <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (state_r == lpbc_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end else begin
        clr_addr_r <= '0;
      end
      cmd_r        <= cmd_nxt;
      pidx_r       <= pidx_nxt;
      col_first_r  <= col_first_nxt;
      col_last_r   <= col_last_nxt;
      row_first_r  <= row_first_nxt;
      row_last_r   <= row_last_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      ramwr_r      <= ramwr_nxt;
      hi_byte_r    <= hi_byte_nxt;
      hi_held_r    <= hi_held_nxt;
      orient_r     <= orient_nxt;
      pin_r        <= pin_nxt;
      last_sweep_r <= last_sweep_nxt;
      disp_r       <= disp_nxt;
      wr_cnt_r     <= wr_cnt_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; a read result is taken from the registered memory output in ST_READ
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_ok_r <= rd_on_panel;
    end
    if (state_r == lpbc_pkg::ST_READ) begin
      out_pixel_r  <= rd_ok_r ? mem_rdata : 16'h0000;
      out_disp_r   <= disp_r;
      out_wr_cnt_r <= wr_cnt_r;
      out_sweep_r  <= sweep_cnt_r;
      out_orient_r <= orient_r;
    end else if (load_out) begin
      out_pixel_r  <= 16'h0000;
      out_disp_r   <= disp_nxt;
      out_wr_cnt_r <= wr_cnt_nxt;
      out_sweep_r  <= sweep_cnt_nxt;
      out_orient_r <= orient_nxt;
    end
  end

  assign in_bus.ready              = in_ready;
  assign out_bus.valid             = out_valid_r;
  assign out_bus.read_pixel        = out_pixel_r;
  assign out_bus.display_enabled   = out_disp_r;
  assign out_bus.pixel_write_count = out_wr_cnt_r;
  assign out_bus.sweep_count       = out_sweep_r;
  assign out_bus.orientation       = out_orient_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpbc_pkg::ST_CLEAR |-> !in_ready)
    else $error("input taken during framebuffer clear");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |=> state_r == lpbc_pkg::ST_READ && !out_valid_r)
    else $error("read result slot not free");

  a_swreset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && act == lpbc_pkg::ACT_CMD && val == lpbc_pkg::CMD_SWRESET
    |=> state_r == lpbc_pkg::ST_CLEAR && clr_addr_r == '0 && wr_cnt_r == 32'd0)
    else $error("software reset did not start clear");

  // off-panel pixels are counted too, so key on the completed byte pair
  a_wr_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && act == lpbc_pkg::ACT_DATA && ramwr_r && hi_held_r) &&
    !(acc && act == lpbc_pkg::ACT_CMD) |=> $stable(wr_cnt_r))
    else $error("write count moved without a pixel");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |-> !load_out)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

@@ tb/lpbc_checker.sv @@
module lpbc_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  lpbc_in_if        in_bus,
  lpbc_out_if       out_bus,
  output int        mismatch_count,
  output int        pending_count
);
  import lpbc_pkg::*;

  localparam int PanelPixels = PanelWidthDef * PanelHeightDef;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              display_on;
    logic [CountW-1:0] writes;
    logic [CountW-1:0] sweeps;
    logic [ByteW-1:0]  orient;
  } panel_status_t;

  panel_status_t status_q[$];

  // shadow of the controller
  logic [PixelW-1:0] frame_mem [PanelPixels];
  logic [ByteW-1:0]  cmd_reg;
  logic [2:0]        param_cnt;
  logic [CoordW-1:0] win_x0, win_x1, win_y0, win_y1;
  logic [CoordW-1:0] cur_x, cur_y;
  logic              pixel_mode, hi_valid, pin_level, display_on;
  logic [ByteW-1:0]  hi_byte, orient;
  int                prev_strip_col;
  logic [CountW-1:0] write_total, sweep_total;

  task automatic restart_engine();
    cmd_reg        = '0;
    param_cnt      = '0;
    win_x0         = '0;
    win_x1         = CoordW'(PanelWidthDef - 1);
    win_y0         = '0;
    win_y1         = CoordW'(PanelHeightDef - 1);
    cur_x          = '0;
    cur_y          = '0;
    pixel_mode     = 1'b0;
    hi_byte        = '0;
    hi_valid       = 1'b0;
    orient         = '0;
    prev_strip_col = -1;
  endtask

  task automatic clear_panel();
    restart_engine();
    foreach (frame_mem[i]) frame_mem[i] = '0;
    display_on  = 1'b0;
    write_total = '0;
  endtask

  task automatic take_pixel_byte(input logic [ByteW-1:0] b);
    if (!hi_valid) begin
      hi_byte  = b;
      hi_valid = 1'b1;
    end else begin
      hi_valid = 1'b0;
      if (cur_x < PanelWidthDef && cur_y < PanelHeightDef)
        frame_mem[int'(cur_y) * PanelWidthDef + int'(cur_x)] = {hi_byte, b};
      write_total = write_total + 1'b1;
      // column-first walk, wraps to the window's top-left
      if ({1'b0, cur_x} + 17'd1 > {1'b0, win_x1}) begin
        cur_x = win_x0;
        if ({1'b0, cur_y} + 17'd1 > {1'b0, win_y1}) cur_y = win_y0;
        else cur_y = cur_y + 1'b1;
      end else begin
        cur_x = cur_x + 1'b1;
      end
    end
  endtask

  // big-endian start/end, high byte clears the low half
  task automatic load_window_byte(inout logic [CoordW-1:0] first, last,
                                  input logic [ByteW-1:0] b);
    case (param_cnt)
      3'd0: first = {b, 8'h00};
      3'd1: first = first | b;
      3'd2: last  = {b, 8'h00};
      3'd3: last  = last | b;
      default: ;
    endcase
  endtask

  task automatic take_data(input logic [ByteW-1:0] b);
    if (pixel_mode) begin
      take_pixel_byte(b);
    end else begin
      if (cmd_reg == CMD_CASET) load_window_byte(win_x0, win_x1, b);
      else if (cmd_reg == CMD_RASET) load_window_byte(win_y0, win_y1, b);
      else if (cmd_reg == CMD_MADCTL) orient = b;
      if (param_cnt < PARAM_SAT) param_cnt = param_cnt + 1'b1;
    end
  endtask

  task automatic take_command(input logic [ByteW-1:0] b);
    cmd_reg    = b;
    param_cnt  = '0;
    pixel_mode = (b == CMD_RAMWR);
    hi_valid   = 1'b0;
    if (pixel_mode) begin
      cur_x = win_x0;
      cur_y = win_y0;
      // single-column window at or left of the last one ends a sweep
      if (win_x1 == win_x0) begin
        if (int'(win_x0) <= prev_strip_col) sweep_total = sweep_total + 1'b1;
        prev_strip_col = int'(win_x0);
      end
    end
    if (b == CMD_DISPON) display_on = 1'b1;
    else if (b == CMD_DISPOFF) display_on = 1'b0;
    else if (b == CMD_SWRESET) clear_panel();
  endtask

  task automatic predict_status(input action_t act, input logic [ByteW-1:0] v,
                                input logic [ReadXW-1:0] x, input logic [ReadYW-1:0] y,
                                output panel_status_t st);
    logic [PixelW-1:0] pix;
    pix = '0;
    case (act)
      ACT_DATA: take_data(v);
      ACT_CMD:  take_command(v);
      ACT_PIN: begin
        if (pin_level && !v[0]) restart_engine();
        pin_level = v[0];
      end
      ACT_READ: begin
        if (x < PanelWidthDef && y < PanelHeightDef)
          pix = frame_mem[int'(y) * PanelWidthDef + int'(x)];
      end
      default: ;
    endcase
    st = '{pix, display_on, write_total, sweep_total, orient};
  endtask

  task automatic check_field(input string name, input logic [CountW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    panel_status_t want, next_status;
    if (!rst_n) begin
      clear_panel();
      pin_level   = 1'b1;
      sweep_total = '0;
      status_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, pixel %0h",
                   $time, out_bus.read_pixel);
          mismatch_count++;
        end else begin
          want = status_q.pop_front();
          check_field("read_pixel", want.pixel, out_bus.read_pixel);
          check_field("display_enabled", want.display_on, out_bus.display_enabled);
          check_field("pixel_write_count", want.writes, out_bus.pixel_write_count);
          check_field("sweep_count", want.sweeps, out_bus.sweep_count);
          check_field("orientation", want.orient, out_bus.orientation);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        predict_status(action_t'(in_bus.action), in_bus.value, in_bus.read_x,
                       in_bus.read_y, next_status);
        status_q.push_back(next_status);
      end
    end
    pending_count = status_q.size();
  end

endmodule

@@ tb/tb_lcd_panel_bus_controller.sv @@
module tb_lcd_panel_bus_controller;
  import lpbc_pkg::*;

  localparam int TotalItems     = 1050;
  localparam int ResetCycles    = 7;
  // A clearing pass keeps in_bus.ready low while all 76800 entries are zeroed;
  // the limit sits above the length of that pass.
  localparam int WatchdogLimit  = 250000;
  localparam int DrainCycles    = 8;
  localparam int RandomSwResets = 3;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   idle_cycles;
  int   sent_items;
  bit   burst_mode;   // both sides run without gaps while set

  // last complete window set by the stimulus, used to aim pixel reads
  int col_lo, col_hi, row_lo, row_hi;
  int strip_col;

  lpbc_in_if  in_bus ();
  lpbc_out_if out_bus ();

  lcd_panel_bus_controller uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  lpbc_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Reset once, released on a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Window start: mostly on the panel, sometimes past its edge or anywhere.
  function automatic int pick_first(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(span, 1023);
    if (r < 12) return $urandom_range(0, 16'hFFFF);
    return $urandom_range(0, span - 1);
  endfunction

  // Window end: usually a few past the start, sometimes inverted or extreme.
  function automatic int pick_last(input int first, input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return (first - 1 - $urandom_range(0, 3)) & 16'hFFFF;
    if (r < 15) return span - 1;
    if (r < 20) return $urandom_range(0, 16'hFFFF);
    return (first + $urandom_range(0, 7)) & 16'hFFFF;
  endfunction

  // Parameter byte count: normally four, sometimes extra or cut short.
  function automatic int pick_param_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 4;
    if (r < 92) return $urandom_range(5, 6);
    return $urandom_range(0, 3);
  endfunction

  // One transaction on in_bus; returns after the accepting edge.
  task automatic bus_write(input action_t act, input logic [ByteW-1:0] v,
                           input logic [ReadXW-1:0] x, input logic [ReadYW-1:0] y);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.value  <= v;
    in_bus.read_x <= x;
    in_bus.read_y <= y;
    do @(posedge clk); while (!in_bus.ready);
    sent_items++;
  endtask

  // unused fields carry random bits
  task automatic send_cmd(input logic [ByteW-1:0] b);
    bus_write(ACT_CMD, b, ReadXW'($urandom), ReadYW'($urandom));
  endtask

  task automatic send_data(input logic [ByteW-1:0] b);
    bus_write(ACT_DATA, b, ReadXW'($urandom), ReadYW'($urandom));
  endtask

  task automatic send_pin(input logic [ByteW-1:0] b);
    bus_write(ACT_PIN, b, ReadXW'($urandom), ReadYW'($urandom));
  endtask

  task automatic send_read(input int x, input int y);
    bus_write(ACT_READ, ByteW'($urandom), x[ReadXW-1:0], y[ReadYW-1:0]);
  endtask

  // Window command with its big-endian start/end; n bytes of it are sent.
  task automatic send_window(input logic [ByteW-1:0] cmd, input int first, last,
                             input int n);
    logic [CoordW-1:0] f, l;
    f = first[CoordW-1:0];
    l = last[CoordW-1:0];
    send_cmd(cmd);
    for (int i = 0; i < n; i++) begin
      case (i)
        0: send_data(f[15:8]);
        1: send_data(f[7:0]);
        2: send_data(l[15:8]);
        3: send_data(l[7:0]);
        default: send_data(ByteW'($urandom));
      endcase
    end
    if (n >= 4) begin
      if (cmd == CMD_CASET) begin
        col_lo = int'((f < l) ? f : l);
        col_hi = int'((f < l) ? l : f);
      end else begin
        row_lo = int'((f < l) ? f : l);
        row_hi = int'((f < l) ? l : f);
      end
    end
  endtask

  // Result side: random stalls, long ready runs while burst_mode is set.
  initial begin
    int stall, run;
    out_bus.ready = 1'b0;
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      run = burst_mode ? 64 : $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any transaction on either side.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(negedge clk); while (idle_cycles < WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int pick, n, first, last, strip, resets_left;
    logic [ByteW-1:0] v;

    in_bus.valid  = 1'b0;
    in_bus.action = ACT_DATA;
    in_bus.value  = '0;
    in_bus.read_x = '0;
    in_bus.read_y = '0;
    sent_items    = 0;
    burst_mode    = 1'b0;
    col_lo        = 0;
    col_hi        = PanelWidthDef - 1;
    row_lo        = 0;
    row_hi        = PanelHeightDef - 1;
    strip_col     = PanelWidthDef - 1;
    resets_left   = RandomSwResets;

    // ---- directed part ----
    send_read(0, 0);                          // cleared store after power-up
    send_cmd(CMD_DISPON);
    send_cmd(CMD_MADCTL);
    send_data(8'hA5);
    // bottom-right corner window, with one surplus parameter byte
    send_window(CMD_CASET, PanelWidthDef - 2, PanelWidthDef - 1, 5);
    send_window(CMD_RASET, PanelHeightDef - 1, PanelHeightDef - 1, 4);
    send_cmd(CMD_RAMWR);
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h01);
    send_read(PanelWidthDef - 1, PanelHeightDef - 1);
    send_read(511, 255);                      // off-panel read gives zero
    send_pin(8'h00);                          // falling edge restarts the engine
    send_pin(8'h01);
    send_cmd(CMD_SWRESET);                    // full clear, long ready-low pass
    send_read(PanelWidthDef - 1, PanelHeightDef - 1);
    col_lo = 0;
    col_hi = PanelWidthDef - 1;
    row_lo = 0;
    row_hi = PanelHeightDef - 1;

    // ---- random part: mostly well-formed command sequences ----
    while (sent_items < TotalItems) begin
      if ($urandom_range(0, 99) < 3) burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 16) begin
        first = pick_first(PanelWidthDef);
        last  = pick_last(first, PanelWidthDef);
        send_window(CMD_CASET, first, last, pick_param_len());
      end else if (pick < 28) begin
        first = pick_first(PanelHeightDef);
        last  = pick_last(first, PanelHeightDef);
        send_window(CMD_RASET, first, last, pick_param_len());
      end else if (pick < 36) begin
        // single-column strip, usually stepping left so sweeps complete
        if ($urandom_range(0, 2) == 0) strip = $urandom_range(0, PanelWidthDef - 1);
        else strip = strip_col - int'($urandom_range(0, 2));
        if (strip < 0) strip = PanelWidthDef - 1;
        strip_col = strip;
        send_window(CMD_CASET, strip, strip, 4);
        send_cmd(CMD_RAMWR);
        repeat (2 * $urandom_range(1, 6)) send_data(ByteW'($urandom));
      end else if (pick < 60) begin
        // pixel stream; odd lengths leave a dangling high byte
        send_cmd(CMD_RAMWR);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 30);
        repeat (n) send_data(ByteW'($urandom));
      end else if (pick < 76) begin
        if ($urandom_range(0, 99) < 70) send_read($urandom_range(col_lo, col_hi),
                                                  $urandom_range(row_lo, row_hi));
        else send_read($urandom_range(0, 511), $urandom_range(0, 255));
      end else if (pick < 81) begin
        send_cmd(CMD_MADCTL);
        repeat ($urandom_range(0, 3)) send_data(ByteW'($urandom));
      end else if (pick < 86) begin
        send_cmd($urandom_range(0, 1) ? CMD_DISPON : CMD_DISPOFF);
      end else if (pick < 90) begin
        send_pin(ByteW'($urandom));
      end else if (pick < 99) begin
        // noise: arbitrary command byte, stray data, or data with no command
        if ($urandom_range(0, 1)) begin
          v = ByteW'($urandom);
          if (v == CMD_SWRESET) v = 8'h00;
          send_cmd(v);
        end
        repeat ($urandom_range(0, 5)) send_data(ByteW'($urandom));
      end else if (resets_left > 0) begin
        // software reset is rare: each one costs a full clearing pass
        resets_left--;
        send_cmd(CMD_SWRESET);
        col_lo = 0;
        col_hi = PanelWidthDef - 1;
        row_lo = 0;
        row_hi = PanelHeightDef - 1;
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    burst_mode = 1'b0;

    // drain: every expected result, then a few quiet cycles for strays
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ lcd_panel_bus_controller.f @@
hw/rtl/lpbc_pkg.sv
hw/rtl/lpbc_if.sv
hw/rtl/lpbc_frame_mem.sv
hw/rtl/lcd_panel_bus_controller.sv
tb/lpbc_checker.sv
tb/tb_lcd_panel_bus_controller.sv
